### hdl/mono_framebuffer_raster_engine_unit_macros.svh
// assertion macros for the raster engine
`ifndef MONO_FRAMEBUFFER_RASTER_ENGINE_UNIT_MACROS_SVH
`define MONO_FRAMEBUFFER_RASTER_ENGINE_UNIT_MACROS_SVH
// assert that antecedent implies consequent on the next clock, off in reset
`define MFRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
// assert that a condition holds on every clock outside reset
`define MFRE_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: check failed");
`endif

### hdl/mfre_pkg.sv
// types and constants shared by the raster engine files
package mfre_pkg;
   typedef enum logic [2:0] {
      MODE_POINT = 3'd0, MODE_LINE = 3'd1, MODE_RECT = 3'd2, MODE_CIRCLE = 3'd3,
      MODE_INVERT = 3'd4, MODE_CLEAR = 3'd5, MODE_READ = 3'd6, MODE_NONE = 3'd7
   } mode_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_LINE_SETUP, ST_LINE_PLOT, ST_CIRC_PLOT, ST_CIRC_STEP,
      ST_INV_PLOT, ST_WAIT_RD, ST_WRITE, ST_RESPOND
   } state_type;

   // what a plot does to its bit
   typedef enum logic [1:0] {
      OP_SET, OP_CLR, OP_FLIP, OP_READ
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic       load;       // latch command fields
      logic       clr_start;  // reset clear counter
      logic       clr_step;   // write zero at clear counter and advance
      logic       line_load;  // set up line from segment
      logic       line_step;  // advance line stepper
      logic       seg_next;   // next rectangle segment
      logic       circ_load;
      logic       circ_step;  // advance midpoint state
      logic       oct_next;   // next of eight symmetric points
      logic       inv_load;
      logic       inv_next;   // next region pixel
      logic       rd_issue;   // present read address for current point
      logic       wr_issue;   // write modified byte
      logic       pix_cap;    // capture read pixel
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       clr_done;
      logic       line_last;
      logic       seg_last;
      logic       circ_done;
      logic       oct_last;
      logic       inv_empty;
      logic       inv_last;
      logic       on_screen;
   } sts_type;
endpackage

### hdl/mfre_if.sv
// valid/ready channel carrying a packed payload
interface mfre_if #(parameter int WIDTH = 8);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hdl/mfre_ram.sv
// single port ram with registered read
module mfre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rd_data <= mem_ff[addr];
   end
endmodule

### hdl/mfre_ctrl.sv
// command sequencer for the raster engine
module mfre_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  mfre_pkg::mode_type  req_mode,
   input  mfre_pkg::mode_type  mode,
   input  logic                rsp_free,
   input  mfre_pkg::sts_type   sts,
   output logic                req_ready,
   output logic                rsp_load,
   output mfre_pkg::cmd_type   cmd,
   output mfre_pkg::state_type state
);
   mfre_pkg::state_type state_ff, state_in;
   assign state = state_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= mfre_pkg::ST_CLEAR;
      else state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfre_pkg::ST_CLEAR: if (sts.clr_done) state_in = mfre_pkg::ST_RESPOND;
         mfre_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_mode)
                  mfre_pkg::MODE_POINT, mfre_pkg::MODE_READ:
                     state_in = mfre_pkg::ST_WAIT_RD;
                  mfre_pkg::MODE_LINE, mfre_pkg::MODE_RECT:
                     state_in = mfre_pkg::ST_LINE_SETUP;
                  mfre_pkg::MODE_CIRCLE: state_in = mfre_pkg::ST_CIRC_PLOT;
                  mfre_pkg::MODE_INVERT: state_in = mfre_pkg::ST_INV_PLOT;
                  mfre_pkg::MODE_CLEAR: state_in = mfre_pkg::ST_CLEAR;
                  default: state_in = mfre_pkg::ST_RESPOND;
               endcase
            end
         end
         mfre_pkg::ST_LINE_SETUP: state_in = mfre_pkg::ST_LINE_PLOT;
         mfre_pkg::ST_LINE_PLOT: state_in = mfre_pkg::ST_WAIT_RD;
         mfre_pkg::ST_CIRC_PLOT: begin
            if (sts.circ_done) state_in = mfre_pkg::ST_RESPOND;
            else state_in = mfre_pkg::ST_WAIT_RD;
         end
         mfre_pkg::ST_CIRC_STEP: state_in = mfre_pkg::ST_CIRC_PLOT;
         mfre_pkg::ST_INV_PLOT: begin
            if (sts.inv_empty) state_in = mfre_pkg::ST_RESPOND;
            else state_in = mfre_pkg::ST_WAIT_RD;
         end
         mfre_pkg::ST_WAIT_RD: state_in = mfre_pkg::ST_WRITE;
         mfre_pkg::ST_WRITE: begin
            unique case (mode)
               mfre_pkg::MODE_LINE, mfre_pkg::MODE_RECT: begin
                  if (!sts.line_last) state_in = mfre_pkg::ST_LINE_PLOT;
                  else if (mode == mfre_pkg::MODE_RECT && !sts.seg_last)
                     state_in = mfre_pkg::ST_LINE_SETUP;
                  else state_in = mfre_pkg::ST_RESPOND;
               end
               mfre_pkg::MODE_CIRCLE: begin
                  if (sts.oct_last) state_in = mfre_pkg::ST_CIRC_STEP;
                  else state_in = mfre_pkg::ST_WAIT_RD;
               end
               mfre_pkg::MODE_INVERT: begin
                  if (sts.inv_last) state_in = mfre_pkg::ST_RESPOND;
                  else state_in = mfre_pkg::ST_WAIT_RD;
               end
               default: state_in = mfre_pkg::ST_RESPOND;
            endcase
         end
         mfre_pkg::ST_RESPOND: if (rsp_free) state_in = mfre_pkg::ST_IDLE;
         default: state_in = mfre_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         mfre_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
         mfre_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cmd.clr_start = 1'b1;
            end
         end
         mfre_pkg::ST_LINE_SETUP: cmd.line_load = 1'b1;
         mfre_pkg::ST_LINE_PLOT: cmd.rd_issue = 1'b1;
         mfre_pkg::ST_CIRC_PLOT: cmd.circ_load = 1'b1;
         mfre_pkg::ST_CIRC_STEP: cmd.circ_step = 1'b1;
         mfre_pkg::ST_INV_PLOT: cmd.inv_load = 1'b1;
         mfre_pkg::ST_WAIT_RD: cmd.pix_cap = 1'b1;
         mfre_pkg::ST_WRITE: begin
            cmd.wr_issue = 1'b1;
            unique case (mode)
               mfre_pkg::MODE_LINE, mfre_pkg::MODE_RECT: begin
                  cmd.line_step = 1'b1;
                  if (sts.line_last) cmd.seg_next = 1'b1;
               end
               mfre_pkg::MODE_CIRCLE: cmd.oct_next = 1'b1;
               mfre_pkg::MODE_INVERT: cmd.inv_next = 1'b1;
               default: ;
            endcase
         end
         mfre_pkg::ST_RESPOND: rsp_load = rsp_free;
         default: ;
      endcase
   end
endmodule

### hdl/mfre_dpath.sv
// coordinate generators and read-modify-write path
module mfre_dpath #(
   parameter int SCREEN_COLUMNS = 180,
   parameter int SCREEN_PAGES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  mfre_pkg::cmd_type   cmd,
   input  mfre_pkg::state_type state,
   input  logic [2:0]          in_mode,
   input  logic [7:0]          in_x_a,
   input  logic [7:0]          in_y_a,
   input  logic [7:0]          in_x_b,
   input  logic [7:0]          in_y_b,
   input  logic [7:0]          in_radius,
   input  logic [7:0]          in_region_width,
   input  logic [7:0]          in_region_height,
   input  logic                in_colour,
   output mfre_pkg::mode_type  mode,
   output logic                pixel,
   output mfre_pkg::sts_type   sts
);
   localparam int ROWS = SCREEN_PAGES * 8;
   localparam int DEPTH = SCREEN_COLUMNS * SCREEN_PAGES;
   localparam int AW = $clog2(DEPTH);
   localparam int PW = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;

   // latched command
   mfre_pkg::mode_type mode_ff;
   logic [7:0] xa_ff, ya_ff, xb_ff, yb_ff, r_ff, w_ff, h_ff;
   logic       col_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mfre_pkg::mode_type'(in_mode);
         xa_ff <= in_x_a; ya_ff <= in_y_a; xb_ff <= in_x_b; yb_ff <= in_y_b;
         r_ff <= in_radius; w_ff <= in_region_width; h_ff <= in_region_height;
         col_ff <= in_colour;
      end
   end
   assign mode = mode_ff;

   // clear sweep
   logic [AW:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset || cmd.clr_start) clr_ff <= '0;
      else if (cmd.clr_step) clr_ff <= clr_ff + 1'b1;
   end
   assign sts.clr_done = (clr_ff == (AW+1)'(DEPTH - 1));

   // line stepper
   logic [1:0]        seg_ff;
   logic signed [9:0] lcx_ff, lcy_ff, lsx_ff, lsy_ff;
   logic [8:0]        ldx_ff, ldy_ff, ldist_ff, lex_ff, ley_ff, ln_ff;
   logic [7:0]        s_x1, s_y1, s_x2, s_y2;
   logic signed [9:0] sdx, sdy;
   logic [8:0]        adx, ady;
   logic [8:0]        ex_n, ey_n;
   always_comb begin
      s_x1 = xa_ff; s_y1 = ya_ff; s_x2 = xb_ff; s_y2 = yb_ff;
      if (mode_ff == mfre_pkg::MODE_RECT) begin
         case (seg_ff)
            2'd0: begin s_x1 = xa_ff; s_y1 = ya_ff; s_x2 = xb_ff; s_y2 = ya_ff; end
            2'd1: begin s_x1 = xa_ff; s_y1 = ya_ff; s_x2 = xa_ff; s_y2 = yb_ff; end
            2'd2: begin s_x1 = xa_ff; s_y1 = yb_ff; s_x2 = xb_ff; s_y2 = yb_ff; end
            default: begin s_x1 = xb_ff; s_y1 = ya_ff; s_x2 = xb_ff; s_y2 = yb_ff; end
         endcase
      end
      sdx = $signed({2'b00, s_x2}) - $signed({2'b00, s_x1});
      sdy = $signed({2'b00, s_y2}) - $signed({2'b00, s_y1});
      adx = sdx[9] ? 9'(-sdx) : 9'(sdx);
      ady = sdy[9] ? 9'(-sdy) : 9'(sdy);
      ex_n = lex_ff + ldx_ff;
      ey_n = ley_ff + ldy_ff;
   end
   always_ff @(posedge clock) begin
      if (cmd.load) seg_ff <= '0;
      else if (cmd.seg_next) seg_ff <= seg_ff + 1'b1;
      if (cmd.line_load) begin
         lcx_ff <= $signed({2'b00, s_x1});
         lcy_ff <= $signed({2'b00, s_y1});
         lsx_ff <= sdx[9] ? -10'sd1 : ((sdx == 0) ? 10'sd0 : 10'sd1);
         lsy_ff <= sdy[9] ? -10'sd1 : ((sdy == 0) ? 10'sd0 : 10'sd1);
         ldx_ff <= adx; ldy_ff <= ady;
         ldist_ff <= (adx > ady) ? adx : ady;
         lex_ff <= '0; ley_ff <= '0; ln_ff <= '0;
      end else if (cmd.line_step) begin
         ln_ff <= ln_ff + 1'b1;
         if (ex_n > ldist_ff) begin
            lex_ff <= ex_n - ldist_ff; lcx_ff <= lcx_ff + lsx_ff;
         end else lex_ff <= ex_n;
         if (ey_n > ldist_ff) begin
            ley_ff <= ey_n - ldist_ff; lcy_ff <= lcy_ff + lsy_ff;
         end else ley_ff <= ey_n;
      end
   end
   assign sts.line_last = ({1'b0, ln_ff} == {1'b0, ldist_ff} + 10'd1);
   assign sts.seg_last = (seg_ff == 2'd3);

   // midpoint circle
   logic [8:0]         ca_ff, cb_ff;
   logic signed [11:0] cd_ff;
   logic [2:0]         oct_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ca_ff <= '0; cb_ff <= {1'b0, in_radius};
         cd_ff <= 12'sd3 - $signed({3'b000, in_radius, 1'b0});
      end else if (cmd.circ_step) begin
         ca_ff <= ca_ff + 1'b1;
         if (cd_ff[11]) cd_ff <= cd_ff + $signed({1'b0, ca_ff, 2'b00}) + 12'sd10;
         else begin
            cd_ff <= cd_ff + 12'sd10 + $signed({1'b0, ca_ff, 2'b00})
                     - $signed({1'b0, cb_ff, 2'b00}) + 12'sd4;
            cb_ff <= cb_ff - 1'b1;
         end
      end
      if (cmd.circ_load) oct_ff <= '0;
      else if (cmd.oct_next) oct_ff <= oct_ff + 1'b1;
   end
   // b may step down to minus one, so compare signed
   assign sts.circ_done = ($signed(ca_ff) > $signed(cb_ff));
   assign sts.oct_last = (oct_ff == 3'd7);
   logic [7:0] pa, pb, cx_pt, cy_pt;
   always_comb begin
      pa = ca_ff[7:0]; pb = cb_ff[7:0];
      case (oct_ff)
         3'd0: begin cx_pt = xa_ff + pa; cy_pt = ya_ff - pb; end
         3'd1: begin cx_pt = xa_ff + pb; cy_pt = ya_ff - pa; end
         3'd2: begin cx_pt = xa_ff + pb; cy_pt = ya_ff + pa; end
         3'd3: begin cx_pt = xa_ff + pa; cy_pt = ya_ff + pb; end
         3'd4: begin cx_pt = xa_ff - pa; cy_pt = ya_ff + pb; end
         3'd5: begin cx_pt = xa_ff - pb; cy_pt = ya_ff + pa; end
         3'd6: begin cx_pt = xa_ff - pa; cy_pt = ya_ff - pb; end
         default: begin cx_pt = xa_ff - pb; cy_pt = ya_ff - pa; end
      endcase
   end

   // invert region scan
   logic [8:0] ix_ff, iy_ff, ixe, iye;
   always_comb begin
      ixe = 9'(xa_ff) + 9'(w_ff);
      if (ixe > 9'(SCREEN_COLUMNS)) ixe = 9'(SCREEN_COLUMNS);
      iye = 9'(ya_ff) + 9'(h_ff);
      if (iye > 9'(ROWS)) iye = 9'(ROWS);
   end
   always_ff @(posedge clock) begin
      if (cmd.inv_load) begin
         ix_ff <= 9'(xa_ff); iy_ff <= 9'(ya_ff);
      end else if (cmd.inv_next) begin
         if (iy_ff + 9'd1 >= iye) begin
            iy_ff <= 9'(ya_ff); ix_ff <= ix_ff + 9'd1;
         end else iy_ff <= iy_ff + 9'd1;
      end
   end
   assign sts.inv_empty = (9'(xa_ff) >= ixe) || (9'(ya_ff) >= iye);
   assign sts.inv_last = (iy_ff + 9'd1 >= iye) && (ix_ff + 9'd1 >= ixe);

   // point select and address
   logic [7:0] px, py;
   always_comb begin
      unique case (mode_ff)
         mfre_pkg::MODE_LINE, mfre_pkg::MODE_RECT: begin
            px = lcx_ff[7:0]; py = lcy_ff[7:0];
         end
         mfre_pkg::MODE_CIRCLE: begin px = cx_pt; py = cy_pt; end
         mfre_pkg::MODE_INVERT: begin px = ix_ff[7:0]; py = iy_ff[7:0]; end
         default: begin px = xa_ff; py = ya_ff; end
      endcase
   end
   assign sts.on_screen = (9'(px) < 9'(SCREEN_COLUMNS)) && (9'(py) < 9'(ROWS));

   logic [AW-1:0] pt_addr, ram_addr;
   logic [AW+8:0] pt_wide;
   assign pt_wide = (AW+9)'(px) * (AW+9)'(SCREEN_PAGES) + (AW+9)'(py >> 3);
   assign pt_addr = pt_wide[AW-1:0];

   logic [7:0] rd_data, wr_data, bit_mask;
   logic       wr_en;
   logic       clearing;
   assign clearing = (state == mfre_pkg::ST_CLEAR);
   assign ram_addr = clearing ? clr_ff[AW-1:0] : pt_addr;
   assign bit_mask = 8'd1 << py[2:0];
   always_comb begin
      unique case (mode_ff)
         mfre_pkg::MODE_INVERT: wr_data = rd_data ^ bit_mask;
         default: wr_data = col_ff ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
      endcase
      if (clearing) wr_data = '0;
   end
   assign wr_en = clearing || (cmd.wr_issue && sts.on_screen &&
                  mode_ff != mfre_pkg::MODE_READ);

   mfre_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .addr(ram_addr), .wr_data(wr_data),
      .rd_data(rd_data)
   );

   // read pixel capture
   logic pix_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) pix_ff <= 1'b0;
      else if (cmd.wr_issue && mode_ff == mfre_pkg::MODE_READ)
         pix_ff <= sts.on_screen & rd_data[py[2:0]];
   end
   assign pixel = pix_ff;
   logic unused;
   assign unused = cmd.rd_issue ^ cmd.pix_cap ^ ^PW'(0);
endmodule

### hdl/mono_framebuffer_raster_engine_unit.sv
// top level of the 1bpp framebuffer raster engine
//
//  channel | dir | payload
//  req     | in  | mode, x_a, y_a, x_b, y_b, radius, region_width, region_height, colour
//  rsp     | out | pixel_value, finished_mode
//
// one command at a time; each plotted point is a read-modify-write of one
// byte through the single frame ram port
// after reset all SCREEN_COLUMNS*SCREEN_PAGES ram bytes (2880 by default) are
// swept to zero before req_ready rises
// rsp register holds a beat until taken; the next command's response waits for it
module mono_framebuffer_raster_engine_unit #(
   parameter int SCREEN_COLUMNS = 180,
   parameter int SCREEN_PAGES = 16
) (
   input logic clock,
   input logic reset,
   mfre_if.sink   req_,
   mfre_if.source rsp_
);
`include "mono_framebuffer_raster_engine_unit_macros.svh"
   mfre_pkg::cmd_type   cmd;
   mfre_pkg::sts_type   sts;
   mfre_pkg::state_type state;
   mfre_pkg::mode_type  mode;
   logic pixel, rsp_load, req_ready;
   logic rsp_valid_ff, rsp_pix_ff;
   logic [2:0] rsp_mode_ff;

   // req payload: {mode, x_a, y_a, x_b, y_b, radius, region_width, region_height, colour}
   // the incoming mode picks the first state, the latched one steers the rest
   mfre_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_.valid),
      .req_mode(mfre_pkg::mode_type'(req_.data[59:57])),
      .mode(mode), .rsp_free(!rsp_valid_ff || rsp_.ready), .sts(sts),
      .req_ready(req_ready), .rsp_load(rsp_load), .cmd(cmd), .state(state)
   );
   assign req_.ready = req_ready;

   mfre_dpath #(.SCREEN_COLUMNS(SCREEN_COLUMNS), .SCREEN_PAGES(SCREEN_PAGES)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .state(state),
      .in_mode(req_.data[59:57]), .in_x_a(req_.data[56:49]), .in_y_a(req_.data[48:41]),
      .in_x_b(req_.data[40:33]), .in_y_b(req_.data[32:25]),
      .in_radius(req_.data[24:17]), .in_region_width(req_.data[16:9]),
      .in_region_height(req_.data[8:1]), .in_colour(req_.data[0]),
      .mode(mode), .pixel(pixel), .sts(sts)
   );

   // result register, {pixel_value, finished_mode}
   logic reset_sweep_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         reset_sweep_ff <= 1'b1;
      end else begin
         if (rsp_load && !reset_sweep_ff) rsp_valid_ff <= 1'b1;
         else if (rsp_.ready) rsp_valid_ff <= 1'b0;
         if (rsp_load) reset_sweep_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_pix_ff <= pixel;
         rsp_mode_ff <= mode;
      end
   end
   assign rsp_.valid = rsp_valid_ff;
   assign rsp_.data = {rsp_pix_ff, rsp_mode_ff};

   `MFRE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_.valid && !rsp_.ready, rsp_.valid)
   `MFRE_ASSERT_ALWAYS(a_busy_no_accept, clock, reset,
      !(req_.ready && state != mfre_pkg::ST_IDLE))
   `MFRE_ASSERT_NEXT(a_read_only_pix, clock, reset,
      rsp_load && mode != mfre_pkg::MODE_READ, rsp_.data[3] == 1'b0)
endmodule

### tb/sv/tb_raster_checker.sv
// beat monitor, framebuffer predictor and response checker for the raster engine
`timescale 1ns / 1ps
module tb_raster_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [59:0] req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_data,
   output int          fail_count,
   output int          pending
);
   localparam int COLS = 180;
   localparam int ROWS = 128;

   typedef struct {
      bit                 pix;
      mfre_pkg::mode_type md;
   } raster_rsp_type;

   bit             frame_bits [0:COLS-1][0:ROWS-1];
   raster_rsp_type owed_rsp[$];

   assign pending = owed_rsp.size();

   function automatic void put_pixel(int x, int y, bit c);
      x = x & 255;
      y = y & 255;
      if (x < COLS && y < ROWS) frame_bits[x][y] = c;
   endfunction

   function automatic bit get_pixel(int x, int y);
      if (x >= COLS || y >= ROWS) return 0;
      return frame_bits[x][y];
   endfunction

   function automatic void trace_line(int x1, int y1, int x2, int y2, bit c);
      int dx, dy, sx, sy, span, ex, ey, cx, cy;
      dx = x2 - x1;
      dy = y2 - y1;
      sx = (dx > 0) ? 1 : (dx == 0) ? 0 : -1;
      sy = (dy > 0) ? 1 : (dy == 0) ? 0 : -1;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      span = (dx > dy) ? dx : dy;
      ex = 0;
      ey = 0;
      cx = x1;
      cy = y1;
      for (int n = 0; n <= span + 1; n++) begin
         put_pixel(cx, cy, c);
         ex += dx;
         ey += dy;
         if (ex > span) begin
            ex -= span;
            cx += sx;
         end
         if (ey > span) begin
            ey -= span;
            cy += sy;
         end
      end
   endfunction

   function automatic void trace_circle(int cx, int cy, int r, bit c);
      int a, b, d;
      a = 0;
      b = r;
      d = 3 - (r * 2);
      while (a <= b) begin
         put_pixel(cx + a, cy - b, c);
         put_pixel(cx + b, cy - a, c);
         put_pixel(cx + b, cy + a, c);
         put_pixel(cx + a, cy + b, c);
         put_pixel(cx - a, cy + b, c);
         put_pixel(cx - b, cy + a, c);
         put_pixel(cx - a, cy - b, c);
         put_pixel(cx - b, cy - a, c);
         a++;
         if (d < 0) d += 4 * a + 6;
         else begin
            d += 10 + 4 * (a - b);
            b--;
         end
      end
   endfunction

   function automatic raster_rsp_type apply_command(logic [59:0] d);
      raster_rsp_type res;
      int xa, ya, xb, yb, xe, ye;
      xa = d[56:49];
      ya = d[48:41];
      xb = d[40:33];
      yb = d[32:25];
      res.pix = 0;
      res.md = mfre_pkg::mode_type'(d[59:57]);
      case (res.md)
         mfre_pkg::MODE_POINT:  put_pixel(xa, ya, d[0]);
         mfre_pkg::MODE_LINE:   trace_line(xa, ya, xb, yb, d[0]);
         mfre_pkg::MODE_RECT: begin
            trace_line(xa, ya, xb, ya, d[0]);
            trace_line(xa, ya, xa, yb, d[0]);
            trace_line(xa, yb, xb, yb, d[0]);
            trace_line(xb, ya, xb, yb, d[0]);
         end
         mfre_pkg::MODE_CIRCLE: trace_circle(xa, ya, int'(d[24:17]), d[0]);
         mfre_pkg::MODE_INVERT: begin
            xe = xa + int'(d[16:9]);
            ye = ya + int'(d[8:1]);
            if (xe > COLS) xe = COLS;
            if (ye > ROWS) ye = ROWS;
            for (int i = xa; i < xe; i++)
               for (int j = ya; j < ye; j++)
                  frame_bits[i][j] = !frame_bits[i][j];
         end
         mfre_pkg::MODE_CLEAR:  foreach (frame_bits[i, j]) frame_bits[i][j] = 0;
         mfre_pkg::MODE_READ:   res.pix = get_pixel(xa, ya);
         default: ;
      endcase
      return res;
   endfunction

   // signals are stable at the falling edge, so a beat seen here lands on the next rise
   always @(negedge clock) begin
      raster_rsp_type want;
      if (reset) begin
         fail_count = 0;
         owed_rsp.delete();
         foreach (frame_bits[i, j]) frame_bits[i][j] = 0;
      end else begin
         if (req_valid && req_ready) owed_rsp.push_back(apply_command(req_data));
         if (rsp_valid && rsp_ready) begin
            if (owed_rsp.size() == 0) begin
               $error("unexpected response beat %h", rsp_data);
               fail_count++;
            end else begin
               want = owed_rsp.pop_front();
               if (rsp_data[3] !== want.pix) begin
                  $error("pixel_value expected %0d actual %0d", want.pix, rsp_data[3]);
                  fail_count++;
               end
               if (rsp_data[2:0] !== want.md) begin
                  $error("finished_mode expected %0d actual %0d", want.md, rsp_data[2:0]);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

### tb/sv/tb.sv
// stimulus, receiver stalls, watchdog and verdict for the raster engine
`timescale 1ns / 1ps
module tb;
   localparam int IDLE_LIMIT = 400000;  // worst invert plus reset sweep, with margin
   localparam int RANDOM_CMDS = 1400;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   idle_cycles;
   int   last_x;
   int   last_y;

   mfre_if #(.WIDTH(60)) req_if ();
   mfre_if #(.WIDTH(4))  rsp_if ();

   mono_framebuffer_raster_engine_unit dut (
      .clock (clock),
      .reset (reset),
      .req_  (req_if),
      .rsp_  (rsp_if)
   );

   tb_raster_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .req_data   (req_if.data),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .rsp_data   (rsp_if.data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // receiver: stall style changes every so often, from always ready to mostly stalled
   int stall_style = 0;
   int style_left = 0;
   always @(posedge clock) begin
      if (style_left == 0) begin
         stall_style <= $urandom_range(0, 3);
         style_left <= $urandom_range(20, 300);
      end else begin
         style_left <= style_left - 1;
      end
      case (stall_style)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= $urandom_range(0, 1);
         2: rsp_if.ready <= ($urandom_range(0, 7) == 0);
         default: rsp_if.ready <= (style_left[3:0] < 4'd6);
      endcase
   end

   // watchdog: cycles with no beat on either channel
   always @(negedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // present one command and hold it until the beat is taken
   task automatic send_cmd(mfre_pkg::mode_type md, int xa, int ya, int xb, int yb, int r,
                           int w, int h, bit c);
      bit taken;
      req_if.valid <= 1'b1;
      req_if.data <= {md, xa[7:0], ya[7:0], xb[7:0], yb[7:0], r[7:0], w[7:0], h[7:0], c};
      if (md == mfre_pkg::MODE_POINT) begin
         last_x = xa;
         last_y = ya;
      end
      do begin
         @(negedge clock);
         taken = req_if.ready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic gap_cycles(int n);
      if (n > 0) begin
         req_if.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic int pick_coord(int span);
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 255);
      return $urandom_range(0, span - 1);
   endfunction

   task automatic send_random();
      int sel, xa, ya;
      mfre_pkg::mode_type md;
      sel = $urandom_range(0, 99);
      xa = pick_coord(180);
      ya = pick_coord(128);
      if (sel < 35) begin
         md = mfre_pkg::MODE_READ;
         // half the reads look where something was just drawn
         if ($urandom_range(0, 1)) begin
            xa = last_x;
            ya = last_y;
         end
      end else if (sel < 55) md = mfre_pkg::MODE_POINT;
      else if (sel < 67) md = mfre_pkg::MODE_LINE;
      else if (sel < 75) md = mfre_pkg::MODE_RECT;
      else if (sel < 84) md = mfre_pkg::MODE_CIRCLE;
      else if (sel < 95) md = mfre_pkg::MODE_INVERT;
      else if (sel < 97) md = mfre_pkg::MODE_CLEAR;
      else md = mfre_pkg::MODE_NONE;
      send_cmd(md, xa, ya, pick_coord(180), pick_coord(128),
               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40),
               ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20),
               ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20),
               $urandom_range(0, 1));
   endtask

   initial begin
      int left, burst;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      last_x = 0;
      last_y = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners, clip edges and wrap
      send_cmd(mfre_pkg::MODE_POINT, 0, 0, 0, 0, 0, 0, 0, 1);
      send_cmd(mfre_pkg::MODE_POINT, 179, 127, 0, 0, 0, 0, 0, 1);
      send_cmd(mfre_pkg::MODE_POINT, 180, 5, 0, 0, 0, 0, 0, 1);
      send_cmd(mfre_pkg::MODE_POINT, 5, 128, 0, 0, 0, 0, 0, 1);
      send_cmd(mfre_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(mfre_pkg::MODE_READ, 179, 127, 0, 0, 0, 0, 0, 0);
      send_cmd(mfre_pkg::MODE_READ, 255, 255, 0, 0, 0, 0, 0, 0);
      send_cmd(mfre_pkg::MODE_POINT, 179, 127, 0, 0, 0, 0, 0, 0);
      send_cmd(mfre_pkg::MODE_READ, 179, 127, 0, 0, 0, 0, 0, 1);
      // lines both ways, with overshoot past the end point
      send_cmd(mfre_pkg::MODE_LINE, 0, 0, 255, 255, 0, 0, 0, 1);
      send_cmd(mfre_pkg::MODE_LINE, 255, 3, 0, 100, 0, 0, 0, 1);
      send_cmd(mfre_pkg::MODE_READ, 50, 50, 0, 0, 0, 0, 0, 0);
      send_cmd(mfre_pkg::MODE_RECT, 10, 120, 170, 2, 0, 0, 0, 1);
      send_cmd(mfre_pkg::MODE_READ, 10, 60, 0, 0, 0, 0, 0, 0);
      // circles: largest radius wraps, zero radius is one point
      send_cmd(mfre_pkg::MODE_CIRCLE, 90, 64, 0, 0, 255, 0, 0, 1);
      send_cmd(mfre_pkg::MODE_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 1);
      send_cmd(mfre_pkg::MODE_READ, 90, 0, 0, 0, 0, 0, 0, 0);
      // invert: whole screen, empty extent, off-screen origin
      send_cmd(mfre_pkg::MODE_INVERT, 0, 0, 0, 0, 0, 255, 255, 0);
      send_cmd(mfre_pkg::MODE_INVERT, 20, 20, 0, 0, 0, 0, 9, 0);
      send_cmd(mfre_pkg::MODE_INVERT, 200, 130, 0, 0, 0, 9, 9, 0);
      send_cmd(mfre_pkg::MODE_READ, 1, 1, 0, 0, 0, 0, 0, 0);
      send_cmd(mfre_pkg::MODE_NONE, 255, 255, 255, 255, 255, 255, 255, 1);
      send_cmd(mfre_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(mfre_pkg::MODE_READ, 1, 1, 0, 0, 0, 0, 0, 0);

      // random part, bursts with or without gaps in between
      left = RANDOM_CMDS;
      while (left > 0) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && left > 0) begin
            send_random();
            burst--;
            left--;
         end
         gap_cycles($urandom_range(0, 1) ? 0 : $urandom_range(1, 30));
      end
      req_if.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule

### mono_framebuffer_raster_engine_unit.f
+incdir+hdl
hdl/mfre_pkg.sv
hdl/mfre_if.sv
hdl/mfre_ram.sv
hdl/mfre_ctrl.sv
hdl/mfre_dpath.sv
hdl/mono_framebuffer_raster_engine_unit.sv
tb/sv/tb_raster_checker.sv
tb/sv/tb.sv
